>>> rtl/core/wnsr_pkg.sv
// ----------------------------------------------------------------------------
// wnsr_pkg
// Shared widths, sizes and the queue entry type of the weight normalize and
// systematic resample unit.
// ----------------------------------------------------------------------------
package wnsr_pkg;

  // particle set size and derived widths
  localparam int unsigned PARTICLES = 64;
  localparam int unsigned IDX_W     = 6;   // particle index
  localparam int unsigned CNT_W     = 7;   // particle count, holds PARTICLES itself
  localparam int unsigned FRAC_W    = 16;  // q0.16 inputs and offset
  localparam int unsigned W_W       = 32;  // product of prior and likelihood
  localparam int unsigned SUM_W     = 38;  // running total of products
  localparam int unsigned PROD_W    = W_W + CNT_W;   // weight times count
  localparam int unsigned LHS_W     = SUM_W + IDX_W; // cumulative weight times count
  localparam int unsigned RHS_W     = 60;  // (offset + n * 2^16) * total
  localparam int unsigned HALF_W    = 19;  // split of the total for the offset product

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  // one classified particle on its way to the back end
  typedef struct packed {
    logic [W_W-1:0]   weight;
    logic [IDX_W-1:0] slot;
    logic             store;  // room left in the set, write it
    logic             last;   // closes the set, start resampling
  } entry_t;

endpackage

>>> rtl/core/wnsr_front.sv
// ----------------------------------------------------------------------------
// wnsr_front
// Input side: forms the particle weight and assigns it a slot in the set.
// ----------------------------------------------------------------------------
module wnsr_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [wnsr_pkg::FRAC_W-1:0] prior_weight_i,
  input  logic [wnsr_pkg::FRAC_W-1:0] likelihood_i,
  input  logic                        last_particle_i,
  input  logic                        q_full_i,
  output logic                        q_push_o,
  output wnsr_pkg::entry_t            q_entry_o
);

  logic [wnsr_pkg::CNT_W-1:0] slot_q, slot_d;
  logic                       room;

  // accept whenever the queue has space
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i & ~q_full_i;

  // classify: store while the set has room
  assign room = (slot_q < wnsr_pkg::CNT_W'(wnsr_pkg::PARTICLES));

  always_comb begin
    q_entry_o.weight = wnsr_pkg::W_W'(prior_weight_i) * wnsr_pkg::W_W'(likelihood_i);
    q_entry_o.slot   = slot_q[wnsr_pkg::IDX_W-1:0];
    q_entry_o.store  = room;
    q_entry_o.last   = last_particle_i;
  end

  // slot counter, restarts after the last particle of a set
  always_comb begin
    slot_d = slot_q;
    if (q_push_o) begin
      if (last_particle_i) begin
        slot_d = '0;
      end else if (room) begin
        slot_d = slot_q + wnsr_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else begin
      slot_q <= slot_d;
    end
  end

endmodule

>>> rtl/core/wnsr_fifo.sv
// ----------------------------------------------------------------------------
// wnsr_fifo
// Short queue of classified particles between the front and the back end.
// ----------------------------------------------------------------------------
module wnsr_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  wnsr_pkg::entry_t entry_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output wnsr_pkg::entry_t entry_o
);

  wnsr_pkg::entry_t                 buf_q [wnsr_pkg::QUEUE_DEPTH];
  logic [wnsr_pkg::QPTR_W-1:0]      wr_q, wr_d, rd_q, rd_d;
  logic [wnsr_pkg::QCNT_W-1:0]      fill_q, fill_d;
  logic                             do_push, do_pop;

  assign full_o  = (fill_q == wnsr_pkg::QCNT_W'(wnsr_pkg::QUEUE_DEPTH));
  assign valid_o = (fill_q != '0);
  assign entry_o = buf_q[rd_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  // pointer and fill update
  always_comb begin
    wr_d   = do_push ? wr_q + wnsr_pkg::QPTR_W'(1) : wr_q;
    rd_d   = do_pop ? rd_q + wnsr_pkg::QPTR_W'(1) : rd_q;
    fill_d = fill_q;
    if (do_push && !do_pop) begin
      fill_d = fill_q + wnsr_pkg::QCNT_W'(1);
    end else if (!do_push && do_pop) begin
      fill_d = fill_q - wnsr_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      fill_q <= fill_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_q] <= entry_i;
    end
  end

endmodule

>>> rtl/core/wnsr_back.sv
// ----------------------------------------------------------------------------
// wnsr_back
// Back end: stores weights and the running total, then walks the cumulative
// weights once per set and emits one resampled index per slot.
// ----------------------------------------------------------------------------
module wnsr_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [wnsr_pkg::FRAC_W-1:0] offset_i,
  input  logic                        q_valid_i,
  input  wnsr_pkg::entry_t            q_entry_i,
  output logic                        q_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [wnsr_pkg::IDX_W-1:0]  selected_index_o,
  output logic                        last_slot_o
);

  localparam logic [2:0] ST_LOAD = 3'd0;
  localparam logic [2:0] ST_PRE0 = 3'd1;
  localparam logic [2:0] ST_PRE1 = 3'd2;
  localparam logic [2:0] ST_PRE2 = 3'd3;
  localparam logic [2:0] ST_WALK = 3'd4;

  localparam int unsigned OFS_W = wnsr_pkg::FRAC_W + wnsr_pkg::HALF_W;

  logic [2:0]                  state_q, state_d;
  logic [wnsr_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [wnsr_pkg::SUM_W-1:0]  sum_q, sum_d;
  logic [wnsr_pkg::IDX_W-1:0]  k_q, k_d, n_q, n_d, fp_q, fp_d;
  logic                        out_valid_q, out_valid_d;

  logic [wnsr_pkg::W_W-1:0]    mem [wnsr_pkg::PARTICLES];
  logic [wnsr_pkg::W_W-1:0]    rd_q;
  logic [wnsr_pkg::PROD_W-1:0] prod_q, mul_w;
  logic [wnsr_pkg::LHS_W-1:0]  lhs_q;
  logic [wnsr_pkg::RHS_W-1:0]  rhs_q;
  logic [OFS_W-1:0]            mul_u;
  logic [wnsr_pkg::IDX_W-1:0]  sel_q;
  logic                        last_q;

  logic pop, mem_we, rd_en, prime, adv, emit, emit_last, out_free;

  // memory write on load, read for prefetch during setup and advance
  assign pop    = (state_q == ST_LOAD) & q_valid_i;
  assign mem_we = pop & q_entry_i.store;
  assign prime  = (state_q == ST_PRE0) | (state_q == ST_PRE1) | (state_q == ST_PRE2);
  assign q_pop_o = pop;

  // weight times count and offset times half of the total
  assign mul_w = wnsr_pkg::PROD_W'(rd_q) * wnsr_pkg::PROD_W'(cnt_q);
  assign mul_u = OFS_W'(offset_i) *
                 OFS_W'((state_q == ST_PRE0) ? sum_q[wnsr_pkg::HALF_W-1:0]
                                             : sum_q[wnsr_pkg::SUM_W-1:wnsr_pkg::HALF_W]);

  // walk decision: advance k while the threshold is not yet passed
  assign out_free  = ~out_valid_q | ~out_stall_i;
  assign adv       = (state_q == ST_WALK) && (sum_q != '0) &&
                     (lhs_q <= rhs_q[wnsr_pkg::RHS_W-1:wnsr_pkg::FRAC_W]) &&
                     ({1'b0, k_q} + wnsr_pkg::CNT_W'(1) < cnt_q);
  assign emit      = (state_q == ST_WALK) & ~adv & out_free;
  assign emit_last = emit & ({1'b0, n_q} + wnsr_pkg::CNT_W'(1) == cnt_q);
  assign rd_en     = prime | adv;

  // sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    k_d         = k_q;
    n_d         = n_q;
    fp_d        = fp_q;
    out_valid_d = out_free ? 1'b0 : out_valid_q;
    case (state_q)
      ST_LOAD: begin
        if (pop) begin
          if (q_entry_i.store) begin
            sum_d = sum_q + wnsr_pkg::SUM_W'(q_entry_i.weight);
            cnt_d = {1'b0, q_entry_i.slot} + wnsr_pkg::CNT_W'(1);
          end
          if (q_entry_i.last) begin
            state_d = ST_PRE0;
            fp_d    = '0;
          end
        end
      end
      ST_PRE0: begin
        state_d = ST_PRE1;
        fp_d    = fp_q + wnsr_pkg::IDX_W'(1);
      end
      ST_PRE1: begin
        state_d = ST_PRE2;
        fp_d    = fp_q + wnsr_pkg::IDX_W'(1);
      end
      ST_PRE2: begin
        state_d = ST_WALK;
        fp_d    = fp_q + wnsr_pkg::IDX_W'(1);
        k_d     = '0;
        n_d     = '0;
      end
      ST_WALK: begin
        if (adv) begin
          k_d  = k_q + wnsr_pkg::IDX_W'(1);
          fp_d = fp_q + wnsr_pkg::IDX_W'(1);
        end else if (emit) begin
          out_valid_d = 1'b1;
          n_d         = n_q + wnsr_pkg::IDX_W'(1);
          if (emit_last) begin
            state_d = ST_LOAD;
            sum_d   = '0;
            cnt_d   = '0;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      cnt_q       <= '0;
      sum_q       <= '0;
      k_q         <= '0;
      n_q         <= '0;
      fp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      sum_q       <= sum_d;
      k_q         <= k_d;
      n_q         <= n_d;
      fp_q        <= fp_d;
      out_valid_q <= out_valid_d;
    end
  end

  // weight memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[q_entry_i.slot] <= q_entry_i.weight;
    end
    if (rd_en) begin
      rd_q <= mem[fp_q];
    end
  end

  // datapath: product pipeline, cumulative and threshold accumulators
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_PRE1) || (state_q == ST_PRE2) || adv) begin
      prod_q <= mul_w;
    end
    if (state_q == ST_PRE2) begin
      lhs_q <= wnsr_pkg::LHS_W'(prod_q);
    end else if (adv) begin
      lhs_q <= lhs_q + wnsr_pkg::LHS_W'(prod_q);
    end
    if (state_q == ST_PRE0) begin
      rhs_q <= wnsr_pkg::RHS_W'(mul_u);
    end else if (state_q == ST_PRE1) begin
      rhs_q <= rhs_q + (wnsr_pkg::RHS_W'(mul_u) << wnsr_pkg::HALF_W);
    end else if (emit) begin
      rhs_q <= rhs_q + (wnsr_pkg::RHS_W'(sum_q) << wnsr_pkg::FRAC_W);
    end
    if (emit) begin
      sel_q  <= (sum_q == '0) ? n_q : k_q;
      last_q <= emit_last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign selected_index_o = sel_q;
  assign last_slot_o      = last_q;

  // walk indices stay inside the loaded set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (({1'b0, k_q} < cnt_q) && ({1'b0, n_q} < cnt_q)))
    else $error("walk index outside particle set");

  // a zero total never moves the cumulative pointer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_WALK) && (sum_q == '0)) |-> (k_q == '0))
    else $error("pointer moved with zero total");

  // cumulative weight never shrinks during a walk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_WALK) && $past(state_q == ST_WALK)) |-> (lhs_q >= $past(lhs_q)))
    else $error("cumulative weight decreased");

  // the queue is not drained while a set is being resampled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_LOAD) |-> !q_pop_o)
    else $error("queue popped during resampling");

endmodule

>>> rtl/core/weight_normalize_systematic_resample_unit.sv
// ----------------------------------------------------------------------------
// weight_normalize_systematic_resample_unit
// Systematic resampling of a weighted particle set of up to 64 particles.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) moves one particle per transfer:
//   prior weight and likelihood, both q0.16. Their product is stored and
//   summed. A transfer with last_particle_i set closes the set.
//   Output channel (out_valid_o / out_stall_i) then moves N transfers, one
//   per slot, each carrying the index of the particle copied into it;
//   last_slot_o marks the final one. A set with a zero total gives index n
//   in slot n.
//   Config channel (cfg_valid_i / cfg_ready_o, always ready) writes the
//   16-bit systematic start offset, a fraction of one slot.
//   Loading takes one particle per cycle while in_stall_o is low. After the
//   closing particle the back end passes its setup states ST_PRE0, ST_PRE1
//   and ST_PRE2, then walks, each step either emitting a slot or moving the
//   cumulative pointer on, paced by the single read port of the weight memory.
//   A two-entry queue keeps taking particles of the next set during a walk
//   and raises in_stall_o once it is full.
//   When out_stall_i is high the output register holds its data and the walk
//   stops at its next slot. Reset clears the set, the offset and the output valid.
// ----------------------------------------------------------------------------
module weight_normalize_systematic_resample_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [wnsr_pkg::FRAC_W-1:0] prior_weight_i,
  input  logic [wnsr_pkg::FRAC_W-1:0] likelihood_i,
  input  logic                        last_particle_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [wnsr_pkg::IDX_W-1:0]  selected_index_o,
  output logic                        last_slot_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [wnsr_pkg::FRAC_W-1:0] cfg_data_i
);

  logic [wnsr_pkg::FRAC_W-1:0] offset_q, offset_d;
  logic                        q_push, q_full, q_valid, q_pop;
  wnsr_pkg::entry_t            q_in, q_out;

  // offset register
  assign cfg_ready_o = 1'b1;
  assign offset_d    = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
    end else begin
      offset_q <= offset_d;
    end
  end

  // front end: weight product and slot assignment
  wnsr_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .prior_weight_i  (prior_weight_i),
    .likelihood_i    (likelihood_i),
    .last_particle_i (last_particle_i),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_entry_o       (q_in)
  );

  // decoupling queue
  wnsr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .entry_o (q_out)
  );

  // back end: storage, total and resampling walk
  wnsr_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .offset_i         (offset_q),
    .q_valid_i        (q_valid),
    .q_entry_i        (q_out),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .selected_index_o (selected_index_o),
    .last_slot_o      (last_slot_o)
  );

endmodule

>>> tb/sv/weight_normalize_systematic_resample_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// weight_normalize_systematic_resample_unit_tb
// Loads particle sets into the resample unit and checks every emitted slot
// index against a cycle-free predictor of the systematic walk or a pinned value.
// A short table of hand-picked sets comes first, then random sets of mixed
// size and weight shape under several start offsets, with random idling on
// both channels and one long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module weight_normalize_systematic_resample_unit_tb;

  localparam int unsigned   RANDOM_ITEMS = 350;
  localparam int unsigned   DRAIN_CYCLES = 2 * wnsr_pkg::PARTICLES + 12;
  localparam int unsigned   LONG_HOLD    = 300;
  localparam int unsigned   CYCLE_LIMIT  = 400000;
  localparam longint unsigned SLOT_ONE   = 64'd65536;
  localparam int unsigned   DIR_ROWS     = 13;
  localparam int unsigned   HOLD_SET     = 12;

  // how the expected slots of a closing table row are obtained
  typedef enum logic [1:0] {
    CHK_MODEL,    // from the predictor
    CHK_UNIFORM,  // slot n carries index n
    CHK_ALL       // every slot carries the pinned index
  } slot_check_e;

  typedef enum logic [1:0] {
    WMODE_FULL,
    WMODE_SPARSE,
    WMODE_ZERO,
    WMODE_TINY
  } weight_mode_e;

  typedef struct packed {
    logic [wnsr_pkg::FRAC_W-1:0] prior;
    logic [wnsr_pkg::FRAC_W-1:0] lik;
    logic                        closes_set;
    slot_check_e                 check;
    logic [wnsr_pkg::IDX_W-1:0]  pin;
  } particle_row_t;

  typedef struct packed {
    logic [wnsr_pkg::IDX_W-1:0] index;
    logic                       last;
  } slot_t;

  logic                        clk_i = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid_q = 1'b0;
  logic [wnsr_pkg::FRAC_W-1:0] prior_q = '0;
  logic [wnsr_pkg::FRAC_W-1:0] lik_q = '0;
  logic                        closes_q = 1'b0;
  logic                        out_stall_q = 1'b0;
  logic                        cfg_valid_q = 1'b0;
  logic [wnsr_pkg::FRAC_W-1:0] cfg_data_q = '0;
  logic                        in_stall_o;
  logic                        out_valid_o;
  logic [wnsr_pkg::IDX_W-1:0]  selected_index_o;
  logic                        last_slot_o;
  logic                        cfg_ready_o;

  // predictor state
  logic [wnsr_pkg::W_W-1:0]    weight_mem [wnsr_pkg::PARTICLES];
  int unsigned                 held_count = 0;
  logic [wnsr_pkg::SUM_W-1:0]  held_sum = '0;
  logic [wnsr_pkg::FRAC_W-1:0] start_offset = '0;
  slot_t                       slot_expect_q [$];

  int unsigned fail_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned stored_particles = 0;
  bit          src_gaps = 1'b1;
  bit          sink_gaps = 1'b1;
  bit          long_hold_req = 1'b0;

  // hand-picked sets, offset at its reset value
  particle_row_t dir_tab [DIR_ROWS] = '{
    // single particle at full scale
    '{16'hFFFF, 16'hFFFF, 1'b1, CHK_ALL,     6'd0},
    // zero total picks slots uniformly
    '{16'h0000, 16'hFFFF, 1'b0, CHK_MODEL,   6'd0},
    '{16'hFFFF, 16'h0000, 1'b0, CHK_MODEL,   6'd0},
    '{16'h0000, 16'h0000, 1'b1, CHK_UNIFORM, 6'd0},
    // only one particle carries weight
    '{16'h0000, 16'h0000, 1'b0, CHK_MODEL,   6'd0},
    '{16'h1234, 16'h0000, 1'b0, CHK_MODEL,   6'd0},
    '{16'hFFFF, 16'hFFFF, 1'b0, CHK_MODEL,   6'd0},
    '{16'h0000, 16'hABCD, 1'b1, CHK_ALL,     6'd2},
    // mixed weights
    '{16'h8000, 16'h8000, 1'b0, CHK_MODEL,   6'd0},
    '{16'h0001, 16'h0001, 1'b0, CHK_MODEL,   6'd0},
    '{16'h5555, 16'hAAAA, 1'b0, CHK_MODEL,   6'd0},
    '{16'hFFFF, 16'h1234, 1'b1, CHK_MODEL,   6'd0},
    // lone particle of zero weight
    '{16'h0000, 16'h0000, 1'b1, CHK_UNIFORM, 6'd0}
  };

  weight_normalize_systematic_resample_unit u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid_q),
    .in_stall_o       (in_stall_o),
    .prior_weight_i   (prior_q),
    .likelihood_i     (lik_q),
    .last_particle_i  (closes_q),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_q),
    .selected_index_o (selected_index_o),
    .last_slot_o      (last_slot_o),
    .cfg_valid_i      (cfg_valid_q),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_q)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // store one particle; on a closing particle queue the resampled slots
  function automatic void resample_particle(input logic [wnsr_pkg::FRAC_W-1:0] prior,
                                            input logic [wnsr_pkg::FRAC_W-1:0] lik,
                                            input logic closes_set,
                                            input slot_check_e check,
                                            input logic [wnsr_pkg::IDX_W-1:0] pin);
    logic [wnsr_pkg::W_W-1:0] w;
    bit [63:0]                cum;
    bit [63:0]                rhs;
    int unsigned              k;
    int unsigned              sel;
    slot_t                    ent;
    if (held_count < wnsr_pkg::PARTICLES) begin
      w = {16'b0, prior} * {16'b0, lik};
      weight_mem[held_count] = w;
      held_sum = held_sum + wnsr_pkg::SUM_W'(w);
      held_count++;
    end
    if (!closes_set) return;
    k = 0;
    cum = 64'(weight_mem[0]);
    for (int unsigned n = 0; n < held_count; n++) begin
      if (held_sum == '0) begin
        sel = n;
      end else begin
        rhs = (64'(start_offset) + 64'(n) * SLOT_ONE) * 64'(held_sum);
        // advance the cumulative pointer past the threshold of slot n
        while (cum * 64'(held_count) * SLOT_ONE <= rhs && k + 1 < held_count) begin
          k++;
          cum = cum + 64'(weight_mem[k]);
        end
        sel = k;
      end
      ent.last = (n + 1 == held_count);
      case (check)
        CHK_UNIFORM: ent.index = wnsr_pkg::IDX_W'(n);
        CHK_ALL:     ent.index = pin;
        default:     ent.index = wnsr_pkg::IDX_W'(sel);
      endcase
      slot_expect_q.insert(slot_expect_q.size(), ent);
    end
    held_count = 0;
    held_sum = '0;
  endfunction

  // offer one particle and wait for its transfer
  task automatic send_particle(input logic [wnsr_pkg::FRAC_W-1:0] prior,
                               input logic [wnsr_pkg::FRAC_W-1:0] lik,
                               input logic closes_set,
                               input slot_check_e check,
                               input logic [wnsr_pkg::IDX_W-1:0] pin);
    int unsigned gap;
    gap = src_gaps ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid_q <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    prior_q    <= prior;
    lik_q      <= lik;
    closes_q   <= closes_set;
    in_valid_q <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    resample_particle(prior, lik, closes_set, check, pin);
  endtask

  // offset write, only while the unit is idle
  task automatic write_offset(input logic [wnsr_pkg::FRAC_W-1:0] value);
    cfg_data_q  <= value;
    cfg_valid_q <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_q <= 1'b0;
    start_offset = value;
  endtask

  // wait out every pending slot and the walk behind it
  task automatic settle();
    in_valid_q <= 1'b0;
    while (slot_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // one random set of the given shape
  task automatic load_set(input int unsigned n_items, input weight_mode_e mode);
    logic [wnsr_pkg::FRAC_W-1:0] prior;
    logic [wnsr_pkg::FRAC_W-1:0] lik;
    for (int unsigned i = 0; i < n_items; i++) begin
      prior = wnsr_pkg::FRAC_W'($urandom);
      lik   = wnsr_pkg::FRAC_W'($urandom);
      case (mode)
        WMODE_SPARSE: if ($urandom_range(0, 1) == 0) lik = '0;
        WMODE_ZERO: begin
          if ($urandom_range(0, 1) == 0) prior = '0;
          else lik = '0;
        end
        WMODE_TINY: begin
          prior = wnsr_pkg::FRAC_W'($urandom_range(0, 3));
          lik   = wnsr_pkg::FRAC_W'($urandom_range(0, 3));
        end
        default: ;
      endcase
      send_particle(prior, lik, i + 1 == n_items, CHK_MODEL, '0);
      if (i < wnsr_pkg::PARTICLES) stored_particles++;
    end
  endtask

  // output side: random stall per transfer, one long hold-off on request
  initial begin : sink
    int unsigned wait_cycles;
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall_q <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
      end
      wait_cycles = sink_gaps ? $urandom_range(0, 5) : 0;
      if (wait_cycles > 0) begin
        out_stall_q <= 1'b1;
        repeat (wait_cycles) @(posedge clk_i);
      end
      out_stall_q <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o && !long_hold_req);
    end
  end

  // slot check against the oldest expectation
  always @(posedge clk_i) begin
    slot_t exp_slot;
    if (rst_n && out_valid_o && !out_stall_q) begin
      if (slot_expect_q.size() == 0) begin
        $error("unexpected transfer: selected_index %0d last_slot %0d",
               selected_index_o, last_slot_o);
        fail_cnt++;
      end else begin
        exp_slot = slot_expect_q.pop_front();
        if (selected_index_o !== exp_slot.index) begin
          $error("selected_index: expected %0d, actual %0d", exp_slot.index,
                 selected_index_o);
          fail_cnt++;
        end
        if (last_slot_o !== exp_slot.last) begin
          $error("last_slot: expected %0d, actual %0d", exp_slot.last, last_slot_o);
          fail_cnt++;
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned                 phase;
    int unsigned                 set_idx;
    int unsigned                 set_size;
    int unsigned                 pick;
    weight_mode_e                mode;
    logic [wnsr_pkg::FRAC_W-1:0] offset;
    phase = 0;
    set_idx = 0;

    // reset
    repeat (5) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // table part
    for (int i = 0; i < DIR_ROWS; i++) begin
      send_particle(dir_tab[i].prior, dir_tab[i].lik, dir_tab[i].closes_set,
                    dir_tab[i].check, dir_tab[i].pin);
    end
    settle();

    // random sets, a new offset each phase
    while (stored_particles < RANDOM_ITEMS) begin
      case (phase)
        0:       offset = 16'hFFFF;
        1:       offset = 16'h0000;
        2:       offset = 16'h0001;
        3:       offset = 16'h8000;
        default: offset = wnsr_pkg::FRAC_W'($urandom);
      endcase
      write_offset(offset);
      src_gaps  = (phase != 1) && ($urandom_range(0, 3) != 0);
      sink_gaps = (phase != 1) && ($urandom_range(0, 3) != 0);
      if (phase == 2) long_hold_req = 1'b1;
      for (int s = 0; s < 3; s++) begin
        // a full set and an overflowing one early, then mostly small sets
        if (set_idx == 0) begin
          set_size = wnsr_pkg::PARTICLES;
        end else if (set_idx == 1) begin
          set_size = wnsr_pkg::PARTICLES + 3;
        end else if (phase == 2) begin
          // sets long enough to back up the queue during the hold-off
          set_size = HOLD_SET;
        end else begin
          pick = $urandom_range(0, 11);
          if (pick == 0) set_size = wnsr_pkg::PARTICLES;
          else if (pick == 1) set_size = wnsr_pkg::PARTICLES + $urandom_range(1, 6);
          else set_size = $urandom_range(1, 12);
        end
        case ($urandom_range(0, 5))
          3:       mode = WMODE_SPARSE;
          4:       mode = WMODE_ZERO;
          5:       mode = WMODE_TINY;
          default: mode = WMODE_FULL;
        endcase
        load_set(set_size, mode);
        set_idx++;
      end
      settle();
      phase++;
    end

    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
